/* rtl/fence_retired_ring_allocator_macros.svh */
// Assertion macros used by the allocator checker.
// No dependencies; included by the checker file.
`ifndef FENCE_RETIRED_RING_ALLOCATOR_MACROS_SVH
`define FENCE_RETIRED_RING_ALLOCATOR_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define FRA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define FRA_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/fra_pkg.sv */
// Shared types and constants of the fence-retired ring allocator.
// No dependencies; used by the interfaces, all modules and the checker.
package fra_pkg;

    localparam int CMD_W    = 2;
    localparam int SIZE_W   = 21;
    localparam int FENCE_W  = 64;
    localparam int STATUS_W = 3;
    localparam int OFFSET_W = 20;
    // size plus (align - 1) stays below 2^22
    localparam int X_W      = SIZE_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_SUBMIT  = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_STALL      = 3'd2,
        ST_TOO_LARGE  = 3'd3,
        ST_QUEUE_FULL = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_RETIRE,
        S_PLACE,
        S_SPACE,
        S_DECIDE,
        S_SUBMIT,
        S_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic latch;    // capture request payload
        logic advance;  // retire the oldest record
        logic place;    // pick grant position, pad to ring start if needed
        logic measure;  // distance from tail to candidate head
        logic decide;   // allocate outcome into response register
        logic submit;   // queue a record, respond
        logic finish;   // respond ok with no payload
    } t_dp_ctl;

    // datapath -> controller
    typedef struct packed {
        t_cmd cmd;
        logic can_retire;
        logic out_free;
    } t_dp_sts;

endpackage

/* rtl/fra_if.sv */
// Request and response channel interfaces of the ring allocator.
// Depends on fra_pkg for field widths.
interface fra_req_if import fra_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [SIZE_W-1:0]   alloc_size;
    logic [FENCE_W-1:0]  fence_value;
    logic [FENCE_W-1:0]  completed_fence;

    modport source (output valid, command, alloc_size, fence_value, completed_fence,
                    input ready);
    modport sink   (input valid, command, alloc_size, fence_value, completed_fence,
                    output ready);
endinterface

interface fra_rsp_if import fra_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] offset;
    logic [FENCE_W-1:0]  wait_fence;

    modport source (output valid, status, offset, wait_fence, input ready);
    modport sink   (input valid, status, offset, wait_fence, output ready);
endinterface

/* rtl/fence_retired_ring_allocator.sv */
// Top level of the fence-retired staging ring allocator.
// Depends on fra_pkg, fra_if, fra_ctrl and fra_datapath.
//
// Usage:
//  - i_req carries one request: allocate (0), submit fence record (1),
//    release completed records (2); code 3 does nothing and answers ok.
//  - o_rsp returns exactly one response per request: status, offset of a
//    granted piece and, on a stall, the fence of the oldest pending record.
//  - Requests are worked one at a time. Ready is high only when the
//    sequencer is idle; a request is taken on valid && ready.
//  - Allocate and release first retire every record whose fence has
//    passed, one per cycle, up to the queue depth; the retire loop reads
//    one queue entry per cycle from the record memories. Allocate then
//    places the piece, measures the free space and decides.
//  - Size rounding uses a reciprocal multiply and a second multiply by
//    the alignment, each registered; they overlap the queue read and retire.
//  - The response register sits between the two sides: the next request is
//    taken while a response still waits. If the receiver stalls, the next
//    request is held at its final step until the response register frees.
//  - Reset (synchronous, active low) empties the queue and puts head and
//    tail at zero. Record memories are not cleared; the count guards reads.
module fence_retired_ring_allocator import fra_pkg::*; #(
    parameter int unsigned RING_BYTES  = 1048576,
    parameter int unsigned ALIGN_BYTES = 256,
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fra_req_if.sink   i_req,
    fra_rsp_if.source o_rsp
);

    t_dp_ctl ctl;
    t_dp_sts sts;

    fra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    fra_datapath #(
        .RING_BYTES  (RING_BYTES),
        .ALIGN_BYTES (ALIGN_BYTES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .o_sts             (sts),
        .i_command         (i_req.command),
        .i_alloc_size      (i_req.alloc_size),
        .i_fence_value     (i_req.fence_value),
        .i_completed_fence (i_req.completed_fence),
        .i_rsp_ready       (o_rsp.ready),
        .o_rsp_valid       (o_rsp.valid),
        .o_status          (o_rsp.status),
        .o_offset          (o_rsp.offset),
        .o_wait_fence      (o_rsp.wait_fence)
    );

endmodule

/* rtl/fra_ctrl.sv */
// Sequencing state machine of the ring allocator.
// Depends on fra_pkg; drives fra_datapath through t_dp_ctl.
module fra_ctrl import fra_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  t_dp_sts i_sts,
    output t_dp_ctl o_ctl
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ctl       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_ctl.latch = 1'b1;
                    n_state     = S_LOAD;
                end
            end
            S_LOAD: begin
                // queue head entry is read this cycle
                unique case (i_sts.cmd) inside
                    CMD_ALLOC, CMD_RELEASE: n_state = S_RETIRE;
                    CMD_SUBMIT:             n_state = S_SUBMIT;
                    default:                n_state = S_FINISH;
                endcase
            end
            S_RETIRE: begin
                if (i_sts.can_retire) begin
                    o_ctl.advance = 1'b1;
                end else if (i_sts.cmd == CMD_ALLOC) begin
                    n_state = S_PLACE;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_PLACE: begin
                o_ctl.place = 1'b1;
                n_state     = S_SPACE;
            end
            S_SPACE: begin
                o_ctl.measure = 1'b1;
                n_state       = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.out_free) begin
                    o_ctl.decide = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SUBMIT: begin
                if (i_sts.out_free) begin
                    o_ctl.submit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_ctl.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/fra_datapath.sv */
// Pointers, record queue memories, size alignment and response register.
// Depends on fra_pkg; steered by fra_ctrl.
module fra_datapath import fra_pkg::*; #(
    parameter int unsigned RING_BYTES  = 1048576,
    parameter int unsigned ALIGN_BYTES = 256,
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_ctl             i_ctl,
    output t_dp_sts             o_sts,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [SIZE_W-1:0]   i_alloc_size,
    input  logic [FENCE_W-1:0]  i_fence_value,
    input  logic [FENCE_W-1:0]  i_completed_fence,
    input  logic                i_rsp_ready,
    output logic                o_rsp_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [OFFSET_W-1:0] o_offset,
    output logic [FENCE_W-1:0]  o_wait_fence
);

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int OFF_W   = $clog2(RING_BYTES);
    localparam int RING_W  = $clog2(RING_BYTES + 1);
    localparam int AL_W    = $clog2(ALIGN_BYTES + 1);
    localparam int SUM_W   = ((RING_W > X_W) ? RING_W : X_W) + 1;
    // floor(x / ALIGN) = (x * MUL) >> SHIFT, exact for x < 2^X_W
    localparam int SHIFT   = X_W + $clog2(ALIGN_BYTES);
    localparam int MUL_W   = X_W + 2;
    localparam int PROD_W  = X_W + MUL_W;
    localparam int QAL_W   = X_W + AL_W;
    localparam logic [MUL_W-1:0] ALIGN_MUL =
        MUL_W'(((64'd1 << SHIFT) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));

    // request capture
    t_cmd                r_cmd;
    logic [SIZE_W-1:0]   r_size;
    logic [FENCE_W-1:0]  r_fval;
    logic [FENCE_W-1:0]  r_done;

    // alignment pipe
    logic [X_W-1:0]      x_val;
    logic [X_W-1:0]      q_val;
    logic [PROD_W-1:0]   r_prod;
    logic [X_W-1:0]      r_aligned;

    // ring pointers; head = base + off
    logic [FENCE_W-1:0]  r_head;
    logic [FENCE_W-1:0]  r_tail;
    logic [FENCE_W-1:0]  r_base;
    logic [OFF_W-1:0]    r_off;
    logic [FENCE_W-1:0]  r_h;
    logic [FENCE_W-1:0]  r_gbase;
    logic [OFF_W-1:0]    r_goff;
    logic [FENCE_W-1:0]  r_used;

    // record queue
    logic [FENCE_W-1:0]  r_fence_mem [QUEUE_DEPTH];
    logic [FENCE_W-1:0]  r_head_mem  [QUEUE_DEPTH];
    logic [FENCE_W-1:0]  r_q_fence;
    logic [FENCE_W-1:0]  r_q_head;
    logic [IDX_W-1:0]    r_rd;
    logic [IDX_W-1:0]    r_wr;
    logic [CNT_W-1:0]    r_count;
    logic [IDX_W-1:0]    rd_next;
    logic [IDX_W-1:0]    wr_next;
    logic [IDX_W-1:0]    rd_addr;
    logic                q_full;
    logic                do_write;

    // response register
    logic                r_o_valid;
    t_status             r_o_status;
    logic [OFFSET_W-1:0] r_o_offset;
    logic [FENCE_W-1:0]  r_o_wait;

    // decision terms
    logic                pad;
    logic [FENCE_W-1:0]  ring_next;
    logic                too_large;
    logic [FENCE_W-1:0]  need;
    logic                short_space;
    logic [SUM_W-1:0]    end_off;
    logic                wrap_end;
    logic                out_free;

    assign x_val  = X_W'(r_size) + X_W'(ALIGN_BYTES - 1);
    assign q_val  = X_W'(r_prod >> SHIFT);

    assign rd_next  = (r_rd == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + IDX_W'(1);
    assign wr_next  = (r_wr == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + IDX_W'(1);
    assign rd_addr  = i_ctl.advance ? rd_next : r_rd;
    assign q_full   = r_count >= CNT_W'(QUEUE_DEPTH);
    assign do_write = i_ctl.submit && !q_full;

    assign pad       = (SUM_W'(r_off) + SUM_W'(r_aligned)) > SUM_W'(RING_BYTES);
    assign ring_next = r_base + 64'(RING_BYTES);

    assign too_large   = SUM_W'(r_aligned) > SUM_W'(RING_BYTES);
    assign need        = r_used + 64'(r_aligned);
    assign short_space = need > 64'(RING_BYTES);
    assign end_off     = SUM_W'(r_goff) + SUM_W'(r_aligned);
    assign wrap_end    = end_off == SUM_W'(RING_BYTES);

    assign out_free = !r_o_valid || i_rsp_ready;

    assign o_sts.cmd        = r_cmd;
    assign o_sts.can_retire = (r_count != '0) && (r_q_fence <= r_done);
    assign o_sts.out_free   = out_free;

    // payload and pipe registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd  <= t_cmd'(i_command);
            r_size <= i_alloc_size;
            r_fval <= i_fence_value;
            r_done <= i_completed_fence;
        end
        r_prod    <= PROD_W'(x_val) * PROD_W'(ALIGN_MUL);
        r_aligned <= X_W'(QAL_W'(q_val) * QAL_W'(ALIGN_BYTES));
        if (i_ctl.place) begin
            r_h     <= pad ? ring_next : r_head;
            r_gbase <= pad ? ring_next : r_base;
            r_goff  <= pad ? '0 : r_off;
        end
        if (i_ctl.measure) begin
            r_used <= r_h - r_tail;
        end
    end

    // record memories
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_fence_mem[r_wr] <= r_fval;
            r_head_mem[r_wr]  <= r_head;
        end
        r_q_fence <= r_fence_mem[rd_addr];
        r_q_head  <= r_head_mem[rd_addr];
    end

    // pointers and queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_base  <= '0;
            r_off   <= '0;
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            if (i_ctl.advance) begin
                r_tail  <= r_q_head;
                r_rd    <= rd_next;
                r_count <= r_count - CNT_W'(1);
            end
            if (do_write) begin
                r_wr    <= wr_next;
                r_count <= r_count + CNT_W'(1);
            end
            if (i_ctl.decide && !too_large && !short_space) begin
                r_head <= r_h + 64'(r_aligned);
                if (wrap_end) begin
                    r_base <= r_gbase + 64'(RING_BYTES);
                    r_off  <= '0;
                end else begin
                    r_base <= r_gbase;
                    r_off  <= OFF_W'(end_off);
                end
            end
        end
    end

    // response
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_ctl.decide || i_ctl.submit || i_ctl.finish) begin
            r_o_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.decide) begin
            r_o_offset <= '0;
            r_o_wait   <= '0;
            if (too_large) begin
                r_o_status <= ST_TOO_LARGE;
            end else if (short_space) begin
                if (r_count == '0) begin
                    r_o_status <= ST_FULL;
                end else begin
                    r_o_status <= ST_STALL;
                    r_o_wait   <= r_q_fence;
                end
            end else begin
                r_o_status <= ST_OK;
                r_o_offset <= OFFSET_W'(r_goff);
            end
        end else if (i_ctl.submit || i_ctl.finish) begin
            r_o_status <= (i_ctl.submit && q_full) ? ST_QUEUE_FULL : ST_OK;
            r_o_offset <= '0;
            r_o_wait   <= '0;
        end
    end

    assign o_rsp_valid  = r_o_valid;
    assign o_status     = r_o_status;
    assign o_offset     = r_o_offset;
    assign o_wait_fence = r_o_wait;

endmodule

/* rtl/fra_checker.sv */
// Port-level checks of the ring allocator, bound to the top level.
// Depends on fra_pkg and fence_retired_ring_allocator_macros.svh.
`include "fence_retired_ring_allocator_macros.svh"

module fra_checker import fra_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [OFFSET_W-1:0] i_offset,
    input logic [FENCE_W-1:0]  i_wait_fence
);

    // one request in flight: ready drops right after a take
    `FRA_ASSERT(a_one_in_flight, i_clk, i_rst_n, (i_req_valid && i_req_ready) |=> !i_req_ready, "request taken while another is in flight")

    // only a granted allocation carries an offset
    `FRA_NEVER(a_offset_only_ok, i_clk, i_rst_n, i_rsp_valid && (i_status != ST_OK) && (i_offset != '0), "offset set on non-ok response")

    // only a stall carries a wait fence
    `FRA_NEVER(a_wait_only_stall, i_clk, i_rst_n, i_rsp_valid && (i_status != ST_STALL) && (i_wait_fence != '0), "wait fence set on non-stall response")

    // a stalled response holds
    `FRA_ASSERT(a_rsp_hold, i_clk, i_rst_n, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_status) && $stable(i_offset) && $stable(i_wait_fence)), "response changed while stalled")

endmodule

bind fence_retired_ring_allocator fra_checker u_fra_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_offset     (o_rsp.offset),
    .i_wait_fence (o_rsp.wait_fence)
);

/* bench/fence_retired_ring_allocator_test.sv */
// Self-checking bench for the fence-retired ring allocator: directed and random requests,
// a request-level predictor of the ring and its submit queue, and randomized handshake pressure.
// Depends on fra_pkg, fra_req_if / fra_rsp_if and fence_retired_ring_allocator.
module fence_retired_ring_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fra_pkg::*;

    // Block configuration (defaults of the DUT)
    localparam longint unsigned RING  = 1048576;
    localparam longint unsigned ALIGN = 256;
    localparam int unsigned     DEPTH = 16;

    localparam int RANDOM_TARGET = 1900;  // total requests built
    localparam int CALM_TAIL     = 120;   // last requests run with no idling
    localparam int TAIL_CYCLES   = 64;    // drain time after the last response
    localparam int LIMIT_CYCLES  = 400000;
    localparam int HOLD_CYCLES   = 250;   // long receiver hold-off

    typedef struct {
        t_cmd               cmd;
        logic [SIZE_W-1:0]  size;
        logic [FENCE_W-1:0] fence;
        logic [FENCE_W-1:0] done;
    } t_ring_request;

    typedef struct {
        t_status             status;
        logic [OFFSET_W-1:0] offset;
        logic [FENCE_W-1:0]  wait_fence;
    } t_ring_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fra_req_if req_ch();
    fra_rsp_if rsp_ch();

    fence_retired_ring_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the ring pointers and submit queue
    // ------------------------------------------------------------------
    logic [63:0] ring_head = '0;
    logic [63:0] ring_tail = '0;
    logic [63:0] rec_fence [DEPTH];
    logic [63:0] rec_head  [DEPTH];
    logic [$clog2(DEPTH)-1:0] rec_rd = '0;
    logic [$clog2(DEPTH)-1:0] rec_wr = '0;
    int unsigned rec_count = 0;

    t_ring_request request_backlog[$];   // built by the stimulus, consumed by the driver
    t_ring_outcome pending_outcomes[$];  // predicted responses, oldest first

    int error_count   = 0;
    int accepted_reqs = 0;
    int send_gap      = 0;
    int stall_left    = 0;
    int hold_left     = 0;
    int hold_count    = 0;
    int cycle_count   = 0;

    // Retire, oldest first, every record whose fence the GPU has passed.
    // The tail jumps to the head captured when that record was submitted.
    function automatic void retire_passed(logic [63:0] done);
        while (rec_count > 0 && rec_fence[rec_rd] <= done) begin
            ring_tail = rec_head[rec_rd];
            rec_rd    = (rec_rd == DEPTH - 1) ? '0 : rec_rd + 1'b1;
            rec_count--;
        end
    endfunction

    // Advance the predictor by one request and return the response it owes.
    function automatic t_ring_outcome ring_outcome(t_ring_request rq);
        t_ring_outcome r;
        logic [63:0]   aligned;
        logic [63:0]   off;
        logic [63:0]   h;
        r.status     = ST_OK;
        r.offset     = '0;
        r.wait_fence = '0;
        case (rq.cmd)
            CMD_ALLOC: begin
                aligned = ((64'(rq.size) + ALIGN - 1) / ALIGN) * ALIGN;
                retire_passed(rq.done);     // retirement happens even when too large
                if (aligned > RING) begin
                    r.status = ST_TOO_LARGE;
                end else begin
                    off = ring_head % RING;
                    h   = ring_head;
                    // a piece never wraps: pad the head to the ring start
                    if (off + aligned > RING) begin
                        h   = h + (RING - off);
                        off = '0;
                    end
                    if ((h - ring_tail) + aligned > RING) begin
                        // short on space: stall on the oldest record, or full
                        if (rec_count == 0) begin
                            r.status = ST_FULL;
                        end else begin
                            r.status     = ST_STALL;
                            r.wait_fence = rec_fence[rec_rd];
                        end
                    end else begin
                        ring_head = h + aligned;
                        r.offset  = off[OFFSET_W-1:0];
                    end
                end
            end
            CMD_SUBMIT: begin
                if (rec_count >= DEPTH) begin
                    r.status = ST_QUEUE_FULL;
                end else begin
                    rec_fence[rec_wr] = rq.fence;
                    rec_head[rec_wr]  = ring_head;
                    rec_wr            = (rec_wr == DEPTH - 1) ? '0 : rec_wr + 1'b1;
                    rec_count++;
                end
            end
            CMD_RELEASE: retire_passed(rq.done);
            default: ;  // no-op answers ok with no payload
        endcase
        return r;
    endfunction

    function automatic void add_request(t_cmd c, logic [SIZE_W-1:0] sz,
                                        logic [FENCE_W-1:0] fv, logic [FENCE_W-1:0] dn);
        t_ring_request rq;
        rq.cmd   = c;
        rq.size  = sz;
        rq.fence = fv;
        rq.done  = dn;
        request_backlog.push_back(rq);
    endfunction

    function automatic void flag_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Idling is off in every third stretch of 150 requests and near the end.
    function automatic bit idling_allowed();
        return ((accepted_reqs / 150) % 3 != 2) && (request_backlog.size() > CALM_TAIL);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: presents the backlog on the request channel and
    // runs the predictor on each request the block accepts.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_ring_request taken;
        t_ring_request nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            send_gap     <= 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                // predict from what the block actually saw on the bus
                taken.cmd   = t_cmd'(req_ch.command);
                taken.size  = req_ch.alloc_size;
                taken.fence = req_ch.fence_value;
                taken.done  = req_ch.completed_fence;
                pending_outcomes.push_back(ring_outcome(taken));
                accepted_reqs <= accepted_reqs + 1;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (send_gap != 0) begin
                    req_ch.valid <= 1'b0;
                    send_gap     <= send_gap - 1;
                end else if (request_backlog.size() == 0) begin
                    req_ch.valid <= 1'b0;
                end else if (hold_left == 0 && idling_allowed() && $urandom_range(0, 5) == 0) begin
                    // random sender gap; keep offering during the long hold
                    req_ch.valid <= 1'b0;
                    send_gap     <= $urandom_range(0, 12);
                end else begin
                    nxt = request_backlog.pop_front();
                    req_ch.valid           <= 1'b1;
                    req_ch.command         <= nxt.cmd;
                    req_ch.alloc_size      <= nxt.size;
                    req_ch.fence_value     <= nxt.fence;
                    req_ch.completed_fence <= nxt.done;
                end
            end
        end
    end

    // Long receiver hold-off, twice in the run, so the response register
    // stays occupied and the block has to stall its request side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            hold_count <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_count < 2 && accepted_reqs >= 400 + 800 * hold_count) begin
            hold_left  <= HOLD_CYCLES;
            hold_count <= hold_count + 1;
        end
    end

    // Response ready: random stall bursts plus the long hold.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
        end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 12);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Response monitor: every accepted response against the oldest prediction.
    always @(posedge i_clk) begin
        t_ring_outcome want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_outcomes.size() == 0) begin
                flag_error($sformatf("response with none outstanding: status %0d offset %h",
                                     rsp_ch.status, rsp_ch.offset));
            end else begin
                want = pending_outcomes.pop_front();
                if (rsp_ch.status !== want.status)
                    flag_error($sformatf("status exp %0d got %0d",
                                         want.status, rsp_ch.status));
                if (rsp_ch.offset !== want.offset)
                    flag_error($sformatf("offset exp %h got %h",
                                         want.offset, rsp_ch.offset));
                if (rsp_ch.wait_fence !== want.wait_fence)
                    flag_error($sformatf("wait_fence exp %h got %h",
                                         want.wait_fence, rsp_ch.wait_fence));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending_outcomes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [FENCE_W-1:0] next_fence;
        logic [FENCE_W-1:0] gpu_done;
        logic [FENCE_W-1:0] noise_done;
        logic [SIZE_W-1:0]  sz;
        int                 gpu_freeze;
        int                 step;

        // Directed: rounding, too-large sizes, no-op, stall, full,
        // exact fit at the ring end, zero size, queue overflow.
        add_request(CMD_ALLOC,   21'd1,          '0, '0);    // rounds to one 256-byte piece
        add_request(CMD_ALLOC,   '1,             '0, '0);    // largest field value, too large
        add_request(CMD_NOP,     '1,             '1, '1);    // no-op command
        add_request(CMD_SUBMIT,  '0,             64'd5, '0);
        add_request(CMD_ALLOC,   21'(RING),      '0, '0);    // pad + stall on fence 5
        add_request(CMD_RELEASE, '0,             '0, 64'd5); // retire it, tail moves
        add_request(CMD_ALLOC,   21'(RING),      '0, '0);    // still short, queue empty: full
        add_request(CMD_ALLOC,   21'(RING - 256), '0, '0);   // ends exactly at the ring end
        add_request(CMD_ALLOC,   '0,             '0, '0);    // zero size at the ring end
        for (int i = 0; i < 16; i++)
            add_request(CMD_SUBMIT, '0, (i == 15) ? '1 : 64'(6 + i), '0);
        add_request(CMD_SUBMIT,  '0,             64'd99, '0); // queue full
        add_request(CMD_RELEASE, '0,             '0, '1);     // retire everything

        // Random: frames of allocations closed by a submit, with a GPU fence
        // that trails the submitted fences and sometimes freezes; in about one
        // draw in ten a single noise request with raw field values takes a frame's place.
        next_fence = 64'd21;
        gpu_done   = 64'd20;
        gpu_freeze = 0;
        while (request_backlog.size() < RANDOM_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0: noise_done = '1;
                    1: noise_done = '0;
                    default: noise_done = {$urandom, $urandom};
                endcase
                add_request(t_cmd'($urandom_range(0, 3)), SIZE_W'($urandom),
                            {$urandom, $urandom}, noise_done);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if (gpu_freeze != 0) begin
                        gpu_freeze--;
                    end else if ($urandom_range(0, 29) == 0) begin
                        gpu_freeze = $urandom_range(20, 80);
                    end else begin
                        step = $urandom_range(0, 3);
                        if (gpu_done + step >= next_fence)
                            gpu_done = next_fence - 1;
                        else
                            gpu_done = gpu_done + step;
                    end
                    case ($urandom_range(0, 19))
                        0:             sz = SIZE_W'($urandom);
                        1, 2:          sz = SIZE_W'($urandom_range(0, RING));
                        3, 4, 5, 6, 7: sz = SIZE_W'($urandom_range(0, 400000));
                        default:       sz = SIZE_W'($urandom_range(0, 65536));
                    endcase
                    add_request(CMD_ALLOC, sz, {$urandom, $urandom}, gpu_done);
                end
                add_request(CMD_SUBMIT, SIZE_W'($urandom), next_fence, gpu_done);
                next_fence = next_fence + 1;
                if ($urandom_range(0, 3) == 0)
                    add_request(CMD_RELEASE, SIZE_W'($urandom), {$urandom, $urandom}, gpu_done);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all requests taken and all responses back, then let the pipe drain
        while (request_backlog.size() != 0 || req_ch.valid || pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/fra_pkg.sv
rtl/fra_if.sv
rtl/fra_ctrl.sv
rtl/fra_datapath.sv
rtl/fence_retired_ring_allocator.sv
rtl/fra_checker.sv
bench/fence_retired_ring_allocator_test.sv
